// ===== hdl/dunn_pkg.sv =====
// shared types and constants for the dunn index block
package dunn_pkg;

  localparam int MaxPointsDef   = 1024;
  localparam int MaxClustersDef = 16;
  localparam int CoordW         = 16;
  localparam int IdW            = 5;
  localparam int DistW          = 17;
  localparam int RatioW         = 32;
  localparam int StatusW        = 2;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StZeroDia = 2'd1;
  localparam logic [StatusW-1:0] StFewClus = 2'd2;
  localparam logic [StatusW-1:0] StBadId   = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [IdW-1:0]           cluster;
    logic                     last;
  } in_word_t;

  typedef struct packed {
    logic [DistW-1:0]   min_between;
    logic [DistW-1:0]   max_within;
    logic [RatioW-1:0]  index_ratio;
    logic [StatusW-1:0] status;
  } out_word_t;

endpackage

// ===== hdl/dunn_ram.sv =====
// generic single-port-write, single-read ram with registered read
module dunn_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/dunn_index_2d.sv =====
// top level of the dunn index block: point load, centroids, pair passes, ratio
//
//  channel | dir | handshake         | word
//  in      | in  | in_valid/in_stall | in_word_t: x, y, cluster, last
//  out     | out | out_valid/out_stall| out_word_t: min_between, max_within, ratio, status
//  cfg     | in  | cfg_we            | cluster_count, 5 bits
//
// points load one a cycle into the point memory and the per-cluster sums.
// on the last point the block computes: centroids (one serial divider),
// centroid pairs (sqrt per pair), point pairs
// (about N*N/2 visits, each same-cluster pair adds an 18-step square root),
// then a 33-step ratio divide. input is stalled from the last point until the
// result is taken. sync reset clears sums, counts and control; memory needs none.
module dunn_index_2d
  import dunn_pkg::*;
#(
  parameter int MaxPoints   = MaxPointsDef,
  parameter int MaxClusters = MaxClustersDef
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic [IdW-1:0] cfg_data
);
  localparam int PA = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int PC = PA + 1;
  localparam int CA = (MaxClusters > 1) ? $clog2(MaxClusters) : 1;
  localparam int CC = CA + 1;
  localparam int SumW = CoordW + PC;

  localparam logic [3:0] S_LOAD = 4'd0, S_CEN = 4'd1, S_CDIV = 4'd2,
    S_CI = 4'd3, S_CJ = 4'd4, S_CSQ = 4'd5, S_PI = 4'd6, S_PIW = 4'd7,
    S_PJ = 4'd8, S_PJW = 4'd9, S_PSQ = 4'd10, S_RAT = 4'd11, S_OUT = 4'd12;

  logic [3:0] state;
  logic [IdW-1:0] cfg_k;

  // per-cluster accumulators (small, fixed reads by index over cycles)
  logic signed [SumW-1:0] sx [MaxClusters];
  logic signed [SumW-1:0] sy [MaxClusters];
  logic [PC-1:0] cnt [MaxClusters];
  logic signed [CoordW:0] cxr [MaxClusters];
  logic signed [CoordW:0] cyr [MaxClusters];
  logic [PC-1:0] loaded;
  logic bad_seen;

  logic [CC-1:0] k_eff;
  always_comb begin
    k_eff = CC'(cfg_k);
    if (cfg_k == '0) k_eff = CC'(1);
    if (32'(cfg_k) > MaxClusters) k_eff = CC'(MaxClusters);
  end

  logic acc;
  logic id_ok;
  logic [CA-1:0] cid;
  assign in_stall = (state != S_LOAD);
  assign acc = in_valid && !in_stall;
  assign id_ok = (in_word.cluster != '0) && ({1'b0, in_word.cluster} <= (IdW+1)'(k_eff));
  assign cid = CA'(in_word.cluster - IdW'(1));

  // point memory
  logic we;
  logic [PA-1:0] raddr;
  logic [2*CoordW+CA-1:0] rdata;
  assign we = acc && id_ok && (loaded < PC'(MaxPoints));
  dunn_ram #(.Width(2*CoordW+CA), .Depth(MaxPoints)) u_pts (
    .clk(clk), .we(we), .waddr(loaded[PA-1:0]),
    .wdata({in_word.x, in_word.y, cid}), .raddr(raddr), .rdata(rdata));

  // working registers
  logic [CC-1:0] ci, cj;
  logic [PC-1:0] pi, pj;
  logic signed [CoordW-1:0] ax, ay;
  logic [CA-1:0] ac;
  logic [CC-1:0] nonempty;
  logic have_min;
  logic [DistW-1:0] minb, maxw;
  logic [1:0] cphase; // 0 x, 1 y

  // serial divider for centroid: q = (2*mag + cnt) / (2*cnt)
  logic [SumW+1:0] dnum, drem;
  logic [PC+1:0]   dden;
  logic [6:0]      dstep;
  logic            dneg;
  logic [SumW+1:0] dq;

  // serial sqrt on 36-bit squares
  logic [35:0] sq_s, sq_r;
  logic [35:0] sq_bit;
  logic        sq_from_c;

  // ratio divider: (minb<<16)/maxw, 33-bit quotient
  logic [DistW+15:0] rnum;
  logic [DistW:0]    rrem;
  logic [DistW+15:0] rq;
  logic [5:0]        rstep;
  logic [RatioW-1:0] ratio;
  logic [StatusW-1:0] stat;

  logic signed [CoordW+1:0] ddx, ddy;
  logic [35:0] sq_in;
  always_comb begin
    if (state == S_CJ) begin
      ddx = (CoordW+2)'(cxr[ci[CA-1:0]]) - (CoordW+2)'(cxr[cj[CA-1:0]]);
      ddy = (CoordW+2)'(cyr[ci[CA-1:0]]) - (CoordW+2)'(cyr[cj[CA-1:0]]);
    end else begin
      ddx = (CoordW+2)'(ax) - (CoordW+2)'($signed(rdata[2*CoordW+CA-1:CoordW+CA]));
      ddy = (CoordW+2)'(ay) - (CoordW+2)'($signed(rdata[CoordW+CA-1:CA]));
    end
  end
  // two squares summed combinationally; the sum is registered into sq_s as the sqrt starts
  logic [35:0] sqx, sqy;
  assign sqx = 36'(ddx * ddx);
  assign sqy = 36'(ddy * ddy);
  assign sq_in = sqx + sqy;

  logic [35:0] sq_t;
  assign sq_t = sq_r + sq_bit;
  logic [DistW-1:0] sq_res;
  assign sq_res = DistW'((sq_s > sq_r) ? sq_r + 36'd1 : sq_r);

  logic [SumW+2:0] dtr;
  assign dtr = {drem, dnum[SumW+1]};
  logic [DistW+1:0] rtr;
  assign rtr = {rrem, rnum[DistW+15]};

  integer n;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cfg_k <= IdW'(16);
      loaded <= '0;
      bad_seen <= 1'b0;
      out_valid <= 1'b0;
      for (n = 0; n < MaxClusters; n++) begin
        sx[n] <= '0; sy[n] <= '0; cnt[n] <= '0;
      end
    end else begin
      if (cfg_we) cfg_k <= cfg_data;
      case (state)
        S_LOAD: begin
          if (acc) begin
            if (!id_ok) bad_seen <= 1'b1;
            else begin
              sx[cid] <= sx[cid] + SumW'(in_word.x);
              sy[cid] <= sy[cid] + SumW'(in_word.y);
              cnt[cid] <= cnt[cid] + PC'(1);
              if (loaded < PC'(MaxPoints)) loaded <= loaded + PC'(1);
            end
            if (in_word.last) begin
              state <= S_CEN;
              ci <= '0;
              cphase <= 2'd0;
              nonempty <= '0;
            end
          end
        end
        S_CEN: begin
          if (ci == k_eff) begin
            state <= S_CI;
            ci <= '0;
            have_min <= 1'b0;
            minb <= '0;
          end else if (cnt[ci[CA-1:0]] == '0) begin
            ci <= ci + CC'(1);
          end else begin
            if (cphase == 2'd0) begin
              dneg <= sx[ci[CA-1:0]] < 0;
              dnum <= (SumW+2)'({(sx[ci[CA-1:0]] < 0 ? -sx[ci[CA-1:0]] : sx[ci[CA-1:0]]), 1'b0})
                      + (SumW+2)'(cnt[ci[CA-1:0]]);
            end else begin
              dneg <= sy[ci[CA-1:0]] < 0;
              dnum <= (SumW+2)'({(sy[ci[CA-1:0]] < 0 ? -sy[ci[CA-1:0]] : sy[ci[CA-1:0]]), 1'b0})
                      + (SumW+2)'(cnt[ci[CA-1:0]]);
            end
            dden <= {1'b0, cnt[ci[CA-1:0]], 1'b0};
            drem <= '0;
            dq <= '0;
            dstep <= '0;
            state <= S_CDIV;
          end
        end
        S_CDIV: begin
          if (dstep == 7'(SumW+2)) begin
            if (cphase == 2'd0) begin
              cxr[ci[CA-1:0]] <= dneg ? -(CoordW+1)'(dq) : (CoordW+1)'(dq);
              cphase <= 2'd1;
            end else begin
              cyr[ci[CA-1:0]] <= dneg ? -(CoordW+1)'(dq) : (CoordW+1)'(dq);
              cphase <= 2'd0;
              nonempty <= nonempty + CC'(1);
              ci <= ci + CC'(1);
            end
            state <= S_CEN;
          end else begin
            dnum <= dnum << 1;
            dstep <= dstep + 7'd1;
            if (dtr >= (SumW+3)'(dden)) begin
              drem <= (SumW+2)'(dtr - (SumW+3)'(dden));
              dq <= {dq[SumW:0], 1'b1};
            end else begin
              drem <= (SumW+2)'(dtr);
              dq <= {dq[SumW:0], 1'b0};
            end
          end
        end
        S_CI: begin
          if (ci == k_eff) begin
            state <= S_PI;
            pi <= '0;
            maxw <= '0;
          end else if (cnt[ci[CA-1:0]] == '0) ci <= ci + CC'(1);
          else begin
            cj <= ci + CC'(1);
            state <= S_CJ;
          end
        end
        S_CJ: begin
          if (cj == k_eff) begin
            ci <= ci + CC'(1);
            state <= S_CI;
          end else if (cnt[cj[CA-1:0]] == '0) cj <= cj + CC'(1);
          else begin
            sq_s <= sq_in;
            sq_r <= '0;
            sq_bit <= 36'h1 << 34;
            sq_from_c <= 1'b1;
            state <= S_CSQ;
          end
        end
        S_CSQ, S_PSQ: begin
          if (sq_bit == '0) begin
            if (sq_from_c) begin
              if (!have_min || sq_res < minb) minb <= sq_res;
              have_min <= 1'b1;
              cj <= cj + CC'(1);
              state <= S_CJ;
            end else begin
              if (sq_res > maxw) maxw <= sq_res;
              pj <= pj + PC'(1);
              state <= S_PJ;
            end
          end else begin
            if (sq_s >= sq_t) begin
              sq_s <= sq_s - sq_t;
              sq_r <= (sq_r >> 1) + sq_bit;
            end else sq_r <= sq_r >> 1;
            sq_bit <= sq_bit >> 2;
          end
        end
        S_PI: begin
          if (pi >= loaded) begin
            state <= S_RAT;
            rnum <= {minb, 16'h0};
            rrem <= '0;
            rq <= '0;
            rstep <= '0;
          end else begin
            state <= S_PIW;
          end
        end
        S_PIW: begin
          ax <= $signed(rdata[2*CoordW+CA-1:CoordW+CA]);
          ay <= $signed(rdata[CoordW+CA-1:CA]);
          ac <= rdata[CA-1:0];
          pj <= pi + PC'(1);
          state <= S_PJ;
        end
        S_PJ: begin
          if (pj >= loaded) begin
            pi <= pi + PC'(1);
            state <= S_PI;
          end else state <= S_PJW;
        end
        S_PJW: begin
          if (rdata[CA-1:0] == ac) begin
            sq_s <= sq_in;
            sq_r <= '0;
            sq_bit <= 36'h1 << 34;
            sq_from_c <= 1'b0;
            state <= S_PSQ;
          end else begin
            pj <= pj + PC'(1);
            state <= S_PJ;
          end
        end
        S_RAT: begin
          if (rstep == 6'(DistW+16)) begin
            if (nonempty < CC'(2)) ratio <= '0;
            else if (maxw == '0) ratio <= (minb != '0) ? '1 : '0;
            else if (rq[DistW+15:RatioW] != '0) ratio <= '1;
            else ratio <= rq[RatioW-1:0];
            if (bad_seen) stat <= StBadId;
            else if (nonempty < CC'(2)) stat <= StFewClus;
            else if (maxw == '0) stat <= StZeroDia;
            else stat <= StOk;
            if (nonempty < CC'(2)) minb <= '0;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            rnum <= rnum << 1;
            rstep <= rstep + 6'd1;
            if (maxw != '0 && rtr >= (DistW+2)'(maxw)) begin
              rrem <= (DistW+1)'(rtr - (DistW+2)'(maxw));
              rq <= {rq[DistW+14:0], 1'b1};
            end else begin
              rrem <= (DistW+1)'(rtr);
              rq <= {rq[DistW+14:0], 1'b0};
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_LOAD;
            loaded <= '0;
            bad_seen <= 1'b0;
            for (n = 0; n < MaxClusters; n++) begin
              sx[n] <= '0; sy[n] <= '0; cnt[n] <= '0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_comb begin
    raddr = pi[PA-1:0];
    if (state == S_PJ) raddr = pj[PA-1:0];
  end

  assign out_word.min_between = minb;
  assign out_word.max_within  = maxw;
  assign out_word.index_ratio = ratio;
  assign out_word.status      = stat;
endmodule
